// ===== rtl/lmc_pkg.sv =====
`timescale 1ns / 1ps

package lmc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int EVC_W = 32;

  // value of the kind field that requests a clear
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } lmc_op_t;

  typedef struct packed {
    lmc_op_t                  op;
    logic signed [KEY_W-1:0]  key;
    logic signed [VAL_W-1:0]  fill;
  } lmc_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_UPDATE
  } lmc_bk_state_t;

  typedef struct packed {
    logic updating;
    logic full;
  } lmc_status_t;

endpackage

// ===== rtl/lmc_front.sv =====
`timescale 1ns / 1ps

module lmc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic signed [31:0]           in_lookup_key,
  input  logic signed [31:0]           in_fill_value,
  output logic                         q_valid,
  output lmc_pkg::lmc_item_t           q_item,
  input  logic                         q_pop
);
  import lmc_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  lmc_item_t        fifo_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  lmc_item_t        item_in;
  logic             push;
  logic             pop;

  // classify the incoming transaction
  always_comb begin
    item_in.op   = (in_kind == KIND_CLEAR) ? OP_CLEAR : OP_LOOKUP;
    item_in.key  = in_lookup_key;
    item_in.fill = in_fill_value;
  end

  assign in_ready = (count_r != CNT_W'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== rtl/lmc_back.sv =====
`timescale 1ns / 1ps

module lmc_back #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  lmc_pkg::lmc_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic signed [31:0]           out_result_value,
  output logic                         out_evicted,
  output logic [31:0]                  out_eviction_total,
  output lmc_pkg::lmc_status_t         status
);
  import lmc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(ENTRIES - 1);

  lmc_bk_state_t state_r, state_nxt;

  // working item
  lmc_op_t                 op_r;
  logic signed [KEY_W-1:0] key_w_r;
  logic signed [VAL_W-1:0] fill_w_r;

  // lookup results
  logic             hit_r, hit_nxt;
  logic             evict_r, evict_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] old_rank_r, old_rank_nxt;
  logic [VAL_W-1:0] rdata_r;

  // stores
  logic signed [KEY_W-1:0] key_r [ENTRIES];
  logic [VAL_W-1:0]        value_mem [ENTRIES];
  logic [IDX_W-1:0]        rank_r [ENTRIES];
  logic [IDX_W-1:0]        rank_nxt [ENTRIES];
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [EVC_W-1:0]        evc_r, evc_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_evicted_r;
  logic [EVC_W-1:0]        out_total_r;

  logic             out_free;
  logic             do_load;
  logic             do_look;
  logic             do_update;
  logic             full;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] match_vec;
  logic             any_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] victim_idx;
  logic             write_miss;

  assign out_free = !out_valid_r || out_ready;
  assign full     = (fill_r == CNT_W'(ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_LOOK;
      BK_LOOK:   state_nxt = BK_UPDATE;
      BK_UPDATE: if (out_free) state_nxt = q_valid ? BK_LOOK : BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    do_load   = 1'b0;
    do_look   = 1'b0;
    do_update = 1'b0;
    case (state_r)
      BK_IDLE:   do_load = q_valid;
      BK_LOOK:   do_look = 1'b1;
      BK_UPDATE: begin
        do_update = out_free;
        do_load   = out_free && q_valid;
      end
      default: ;
    endcase
  end

  assign q_pop = do_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      op_r     <= q_item.op;
      key_w_r  <= q_item.key;
      fill_w_r <= q_item.fill;
    end
  end

  // parallel tag compare and one-hot encode
  always_comb begin
    hit_idx    = '0;
    hit_rank   = '0;
    victim_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = (CNT_W'(i) < fill_r);
      match_vec[i] = valid_vec[i] && (key_r[i] == key_w_r);
      if (match_vec[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (full && rank_r[i] == RANK_MAX) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end
    any_hit = |match_vec;
  end

  always_comb begin
    hit_nxt   = any_hit;
    evict_nxt = !any_hit && full;
    if (any_hit) begin
      slot_nxt     = hit_idx;
      old_rank_nxt = hit_rank;
    end else if (full) begin
      slot_nxt     = victim_idx;
      old_rank_nxt = RANK_MAX;
    end else begin
      slot_nxt     = fill_r[IDX_W-1:0];
      old_rank_nxt = fill_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (do_look) begin
      hit_r      <= hit_nxt;
      evict_r    <= evict_nxt;
      slot_r     <= slot_nxt;
      old_rank_r <= old_rank_nxt;
    end
  end

  assign write_miss = do_update && (op_r == OP_LOOKUP) && !hit_r;

  // value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (write_miss) begin
      value_mem[slot_r] <= fill_w_r;
    end
    if (do_look) begin
      rdata_r <= value_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (write_miss) begin
      key_r[slot_r] <= key_w_r;
    end
  end

  // recency rank update, fill count and eviction count
  always_comb begin
    fill_nxt = fill_r;
    evc_nxt  = evc_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (do_update) begin
      if (op_r == OP_CLEAR) begin
        fill_nxt = '0;
        evc_nxt  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_nxt[i] = '0;
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot_r) begin
            rank_nxt[i] = '0;
          end else if (valid_vec[i] && rank_r[i] < old_rank_r) begin
            rank_nxt[i] = IDX_W'(rank_r[i] + 1'b1);
          end
        end
        if (!hit_r && !evict_r) begin
          fill_nxt = CNT_W'(fill_r + 1'b1);
        end
        if (evict_r) begin
          evc_nxt = EVC_W'(evc_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      evc_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
      evc_r  <= evc_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      if (op_r == OP_CLEAR) begin
        out_hit_r     <= 1'b0;
        out_value_r   <= '0;
        out_evicted_r <= 1'b0;
        out_total_r   <= '0;
      end else begin
        out_hit_r     <= hit_r;
        out_value_r   <= hit_r ? rdata_r : fill_w_r;
        out_evicted_r <= evict_r;
        out_total_r   <= evc_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_result_value   = out_value_r;
  assign out_evicted        = out_evicted_r;
  assign out_eviction_total = out_total_r;

  assign status.updating = do_update;
  assign status.full     = full;

endmodule

// ===== rtl/lru_memo_cache.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_kind, in_lookup_key, in_fill_value
// out       output     out_valid / out_ready out_hit, out_result_value, out_evicted,
//                                            out_eviction_total
//
// in the back end every transaction passes the parallel key compare over all entries,
// then the recency rank update and store write
// a 2-deep queue in front accepts new transactions while the back end works
// synchronous active-low reset empties the cache, ranks and eviction count
// the back end holds in its update step while a finished result is not taken

module lru_memo_cache #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic signed [31:0] in_lookup_key,
  input  logic signed [31:0] in_fill_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [31:0] out_result_value,
  output logic               out_evicted,
  output logic [31:0]        out_eviction_total
);
  import lmc_pkg::*;

  // queue between front and back
  logic        q_valid;
  lmc_item_t   q_item;
  logic        q_pop;
  lmc_status_t status;

  // front: accept and classify, buffer in a short queue
  lmc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_lookup_key (in_lookup_key),
    .in_fill_value (in_fill_value),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: tag compare, lru replacement, result register
  lmc_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_result_value   (out_result_value),
    .out_evicted        (out_evicted),
    .out_eviction_total (out_eviction_total),
    .status             (status)
  );

  // an eviction only happens once every entry is filled
  a_evict_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> status.full)
    else $error("eviction reported while cache not full");

  // a hit never evicts
  a_hit_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted)
    else $error("hit and eviction reported together");

  // every update step presents a result on the next cycle
  a_update_result : assert property (@(posedge clk) disable iff (!rst_n)
    status.updating |=> out_valid)
    else $error("update step produced no result");

endmodule

// ===== dv/lru_memo_cache_tb.sv =====
`timescale 1ns / 1ps

module lru_memo_cache_tb;
  import lmc_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int RAND_ITEMS = 1900;
  localparam int TAIL      = 300;      // last transactions run with no idling
  localparam int LIMIT     = 400000;   // cycle budget
  localparam int DRAIN     = 20;       // settle cycles once nothing is outstanding

  // one queued lookup or clear; hold makes the driver wait for all answers first
  typedef struct {
    lmc_op_t     op;
    logic [31:0] key;
    logic [31:0] fill;
    bit          hold;
  } cache_req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic        evicted;
    logic [31:0] total;
  } cache_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = 1'b0;
  logic signed [31:0] in_lookup_key = '0;
  logic signed [31:0] in_fill_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_result_value;
  logic               out_evicted;
  logic [31:0]        out_eviction_total;

  cache_req_t    access_queue[$];
  cache_answer_t answer_queue[$];

  // shadow copy of the cache contents and bookkeeping
  logic [31:0] shadow_key [ENTRIES];
  logic [31:0] shadow_val [ENTRIES];
  logic [3:0]  shadow_rank[ENTRIES];
  logic [4:0]  shadow_fill;
  logic [31:0] shadow_evictions;

  int errors = 0;
  int cycle_cnt = 0;
  int sent_cnt = 0;      // input transactions, owned by the driver
  int got_cnt = 0;       // output transactions, nonblocking, owned by the monitor
  int total_items = 0;
  int hits_seen = 0, evicts_seen = 0, clears_seen = 0;
  int in_gap_pct = 0, out_gap_pct = 0;
  int in_gap_left = 0, rdy_gap_left = 0;

  lru_memo_cache #(.ENTRIES(ENTRIES)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_lookup_key     (in_lookup_key),
    .in_fill_value     (in_fill_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_result_value  (out_result_value),
    .out_evicted       (out_evicted),
    .out_eviction_total(out_eviction_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // empty the shadow cache, as reset and a clear both do
  function automatic void shadow_clear();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_rank[i] = '0;
    end
    shadow_fill      = '0;
    shadow_evictions = '0;
  endfunction

  // age every filled slot younger than old_rank, then make slot idx the newest
  function automatic void shadow_promote(int idx, logic [3:0] old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i < shadow_fill && shadow_rank[i] < old_rank) shadow_rank[i] = shadow_rank[i] + 1'b1;
    end
    shadow_rank[idx] = '0;
  endfunction

  // work out the answer to one accepted transaction and queue it
  function automatic void apply_cache_access(lmc_op_t op, logic [31:0] key, logic [31:0] fill);
    cache_answer_t ans;
    int            slot;
    bit            found;
    ans   = '0;
    found = 1'b0;
    slot  = 0;
    if (op == OP_CLEAR) begin
      // clear ignores key and fill, answers all zero
      shadow_clear();
      clears_seen++;
      answer_queue.push_back(ans);
      return;
    end
    // only filled slots are ever compared
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && i < shadow_fill && shadow_key[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      shadow_promote(slot, shadow_rank[slot]);
      ans.hit   = 1'b1;
      ans.value = shadow_val[slot];
      ans.total = shadow_evictions;
      hits_seen++;
    end else begin
      if (shadow_fill < ENTRIES) begin
        // free slot: new entry starts oldest, then moves to the front
        slot = shadow_fill;
        shadow_fill = shadow_fill + 1'b1;
        shadow_rank[slot] = 4'(shadow_fill - 1'b1);
        shadow_promote(slot, shadow_rank[slot]);
      end else begin
        // full: the victim is the slot with the largest rank
        slot = 0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (shadow_rank[i] > shadow_rank[slot]) slot = i;
        end
        shadow_promote(slot, shadow_rank[slot]);
        shadow_evictions = shadow_evictions + 1;
        ans.evicted = 1'b1;
        evicts_seen++;
      end
      shadow_key[slot] = key;
      shadow_val[slot] = fill;
      ans.value = fill;
      ans.total = shadow_evictions;
    end
    answer_queue.push_back(ans);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_access(lmc_op_t op, logic [31:0] key, logic [31:0] fill, bit hold);
    cache_req_t r;
    r.op   = op;
    r.key  = key;
    r.fill = fill;
    r.hold = hold;
    access_queue.push_back(r);
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 45;
    endcase
  endfunction

  // cycle budget and slowly changing idle density on both sides
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still due", cycle_cnt, answer_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (cycle_cnt % 200 == 0) begin
      in_gap_pct  <= pick_gap_pct();
      out_gap_pct <= pick_gap_pct();
    end
  end

  // driver: pops the front transaction once accepted, then decides what comes next
  always @(posedge clk) begin : driver
    bit show;
    int outstanding;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        void'(access_queue.pop_front());
        sent_cnt++;
      end
      // valid stays up with the same payload until the transaction goes through
      if (!(in_valid && !in_ready)) begin
        show = 1'b0;
        // answers still due once this edge settles
        outstanding = sent_cnt - got_cnt - ((out_valid && out_ready) ? 1 : 0);
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (access_queue.size() > TAIL && $urandom_range(0, 99) < in_gap_pct) begin
          in_gap_left = $urandom_range(0, 14);
        end else if (access_queue.size() > 0) begin
          // a hold transaction waits until the block has answered everything
          show = !access_queue[0].hold || outstanding == 0;
        end
        in_valid <= show;
        if (show) begin
          in_kind       <= access_queue[0].op;
          in_lookup_key <= access_queue[0].key;
          in_fill_value <= access_queue[0].fill;
        end
      end
    end
  end

  // monitor: checks each answer, then predicts from the transaction taken at this edge
  always @(posedge clk) begin : monitor
    cache_answer_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_cnt <= got_cnt + 1;
        if (answer_queue.size() == 0) begin
          $display("%0t unexpected result: expected none actual hit=%b value=%h", $time,
                   out_hit, out_result_value);
          errors++;
        end else begin
          want = answer_queue.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("result_value", want.value, out_result_value);
          check_field("evicted", 32'(want.evicted), 32'(out_evicted));
          check_field("eviction_total", want.total, out_eviction_total);
        end
      end
      // port values are the accepted payload, stable since they change only on nba
      if (in_valid && in_ready)
        apply_cache_access(lmc_op_t'(in_kind), in_lookup_key, in_fill_value);
      // receiver stalls in bursts, none near the end
      if (rdy_gap_left > 0) begin
        rdy_gap_left--;
        out_ready <= 1'b0;
      end else if (got_cnt + TAIL < total_items && $urandom_range(0, 99) < out_gap_pct) begin
        rdy_gap_left = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] pool[64];
    int          n_rand;
    int          seg_len;
    int          pool_sz;
    int          r;
    logic [31:0] key;
    n_rand = 0;
    shadow_clear();

    // directed: extreme keys and fills miss first, then hit
    queue_access(OP_LOOKUP, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    queue_access(OP_LOOKUP, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    queue_access(OP_LOOKUP, 32'h0000_0000, 32'hffff_ffff, 1'b0);
    queue_access(OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 1'b0);
    queue_access(OP_LOOKUP, 32'h7fff_ffff, 32'h1234_5678, 1'b0);
    queue_access(OP_LOOKUP, 32'h0000_0000, 32'h5555_5555, 1'b0);
    // fill the remaining slots until the cache is full
    for (int i = 0; i < ENTRIES - 4; i++)
      queue_access(OP_LOOKUP, 32'h0000_1000 + i, 32'ha5a5_0000 + i, 1'b0);
    // refresh the oldest entry so the next miss must evict a different one
    queue_access(OP_LOOKUP, 32'h8000_0000, 32'h0, 1'b0);
    queue_access(OP_LOOKUP, 32'hdead_beef, 32'hcafe_f00d, 1'b0);
    queue_access(OP_LOOKUP, 32'h8000_0000, 32'h0, 1'b0);
    // clear with nonzero key and fill that must be ignored, after a full drain
    queue_access(OP_CLEAR, 32'hffff_ffff, 32'h7fff_ffff, 1'b1);
    queue_access(OP_LOOKUP, 32'h8000_0000, 32'h0bad_0bad, 1'b0);

    // random: segments with a working set around the cache size, plus noise and clears
    while (n_rand < RAND_ITEMS) begin
      seg_len = $urandom_range(40, 160);
      case ($urandom_range(0, 6))
        0:       pool_sz = 4;
        1:       pool_sz = 12;
        2:       pool_sz = 16;
        3:       pool_sz = 17;
        4:       pool_sz = 20;
        5:       pool_sz = 32;
        default: pool_sz = 64;
      endcase
      for (int i = 0; i < 64; i++) begin
        case ($urandom_range(0, 15))
          0:       pool[i] = 32'h8000_0000;
          1:       pool[i] = 32'h7fff_ffff;
          2:       pool[i] = 32'h0;
          3:       pool[i] = 32'hffff_ffff;
          default: pool[i] = $urandom;
        endcase
      end
      for (int j = 0; j < seg_len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          queue_access(OP_CLEAR, $urandom, $urandom, 1'b0);
        end else begin
          key = (r < 10) ? 32'($urandom) : pool[$urandom_range(0, pool_sz - 1)];
          // the first item overall and some segment starts wait for a full drain
          queue_access(OP_LOOKUP, key, $urandom,
                       (j == 0) && (n_rand == 0 || $urandom_range(0, 2) == 0));
        end
        n_rand++;
      end
    end
    total_items = access_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // everything sent and answered, then let the block settle
    do @(negedge clk); while (access_queue.size() != 0 || answer_queue.size() != 0);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d transactions: %0d hits, %0d evictions, %0d clears",
             total_items, hits_seen, evicts_seen, clears_seen);
    $display("cache ran from empty to full with lru victims under random stalls on both sides");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lmc_pkg.sv
rtl/lmc_front.sv
rtl/lmc_back.sv
rtl/lru_memo_cache.sv
dv/lru_memo_cache_tb.sv
